// File: hw/rtl/ias_pkg.sv
package ias_pkg;

   localparam int WORD_W        = 32;
   localparam int INDEX_W       = 16;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 9;
   localparam int DEPTH_DEFAULT = 256;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [WORD_W-1:0]   word_type;

   localparam action_type ACT_APPEND = 3'd0;
   localparam action_type ACT_INSERT = 3'd1;
   localparam action_type ACT_GET    = 3'd2;
   localparam action_type ACT_REMOVE = 3'd3;
   localparam action_type ACT_CLEAR  = 3'd4;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_EMPTY   = 2'd2;
   localparam status_type ST_FULL    = 2'd3;

endpackage

// File: hw/rtl/ias_ram.sv
module ias_ram #(
   parameter int DEPTH = ias_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  ias_pkg::word_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output ias_pkg::word_type rd_data
);
   import ias_pkg::*;

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/indexed_array_store.sv
// Bounded array of DEPTH signed 32-bit words with an element count, held in one
// single-port-write, single-port-read synchronous memory. Each request item
// carries one action (append, insert at index, get, remove at index, clear) and
// returns exactly one result item with a status, the word read by a get and the
// element count after the request (its low 9 bits). The block works on one item
// at a time: append, clear, an insert that lands inside or at the end of the
// used range and every rejected request go straight from acceptance to S_EMIT,
// and a get first waits in S_GET for the registered memory read. An insert
// beyond the end writes one zero a cycle to pad the gap before it writes its
// value, and a remove moves one later element down a cycle through the
// memory's read and write ports. The longest request is an insert at the last
// slot of an empty array. Clear only resets the count, because entries above
// the count are always rewritten before they are read.
// A new item is accepted as soon as the previous one has handed its result to
// the output register, even while that result still waits behind rsp_stall.
module indexed_array_store #(
   parameter int DEPTH = ias_pkg::DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ias_pkg::action_type req_action,
   input  logic signed [ias_pkg::INDEX_W-1:0] req_index,
   input  logic signed [ias_pkg::WORD_W-1:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ias_pkg::status_type rsp_status,
   output logic signed [ias_pkg::WORD_W-1:0]  rsp_read_value,
   output logic [ias_pkg::COUNT_W-1:0]        rsp_count
);
   import ias_pkg::*;

   // Address width of the store and width of a counter that can hold DEPTH.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GET   = 3'd1;
   localparam logic [2:0] S_PAD   = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;     // pad write pointer or shift read pointer
   logic [CW-1:0] pos_ff, pos_in;     // target position of an insert
   word_type      val_ff, val_in;     // word that an insert writes last
   status_type    st_ff, st_in;       // result waiting to be emitted
   word_type      rd_ff, rd_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff;
   word_type      rsp_value_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // Memory port controls.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   word_type      wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   word_type      rd_data;

   // Request decode helpers; the index, count and depth are compared at 32 bits.
   logic          accept;
   logic          idx_neg;
   logic [31:0]   idx_u32;
   logic [31:0]   count32;
   logic [31:0]   depth32;
   logic [CW-1:0] idx_pos;
   logic [CW-1:0] ptr_next;
   logic          out_free;

   assign accept   = req_valid && !req_stall;
   assign idx_neg  = req_index[INDEX_W-1];
   assign idx_u32  = {{(32 - INDEX_W){1'b0}}, req_index};
   assign count32  = 32'(count_ff);
   assign depth32  = 32'(DEPTH);
   assign idx_pos  = idx_u32[CW-1:0];
   assign ptr_next = ptr_ff + CW'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);

   ias_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      st_in    = st_ff;
      rd_in    = rd_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_data  = req_value;
      rd_en    = 1'b0;
      rd_addr  = idx_pos[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               st_in    = ST_OK;
               rd_in    = '0;
               state_in = S_EMIT;
               case (req_action)
                  ACT_APPEND: begin
                     if (count32 >= depth32) begin
                        st_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ACT_INSERT: begin
                     if (idx_neg) begin
                        st_in = ST_INVALID;
                     end else if (idx_u32 >= depth32) begin
                        st_in = ST_FULL;
                     end else if (idx_u32 > count32) begin
                        // Gap above the used range: pad with zeros first.
                        ptr_in   = count_ff;
                        pos_in   = idx_pos;
                        val_in   = req_value;
                        state_in = S_PAD;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = idx_pos[AW-1:0];
                        if (idx_u32 == count32) begin
                           count_in = count_ff + CW'(1);
                        end
                     end
                  end
                  ACT_GET: begin
                     if (idx_neg || idx_u32 >= count32) begin
                        st_in = ST_INVALID;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_pos[AW-1:0];
                        state_in = S_GET;
                     end
                  end
                  ACT_REMOVE: begin
                     if (idx_neg || idx_u32 >= count32) begin
                        st_in = ST_INVALID;
                     end else if (idx_u32 + 32'd1 >= count32) begin
                        // Last element: nothing to move.
                        count_in = count_ff - CW'(1);
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_pos[AW-1:0] + AW'(1);
                        ptr_in   = idx_pos + CW'(1);
                        state_in = S_SHIFT;
                     end
                  end
                  ACT_CLEAR: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;
                     end else begin
                        count_in = '0;
                     end
                  end
                  default: begin
                     st_in = ST_INVALID;
                  end
               endcase
            end
         end
         S_GET: begin
            rd_in    = rd_data;
            state_in = S_EMIT;
         end
         S_PAD: begin
            wr_en = 1'b1;
            if (ptr_ff < pos_ff) begin
               wr_addr = ptr_ff[AW-1:0];
               wr_data = '0;
               ptr_in  = ptr_next;
            end else begin
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = val_ff;
               count_in = pos_ff + CW'(1);
               state_in = S_EMIT;
            end
         end
         S_SHIFT: begin
            // The word read last cycle moves one place down.
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0] - AW'(1);
            wr_data = rd_data;
            if (ptr_next < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_next[AW-1:0];
               ptr_in  = ptr_next;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      st_ff  <= st_in;
      rd_ff  <= rd_in;
      if (state_ff == S_EMIT && out_free) begin
         rsp_status_ff <= st_ff;
         rsp_value_ff  <= rd_ff;
         rsp_count_ff  <= count32[COUNT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count      = rsp_count_ff;

endmodule
